// ----- rtl/core/stepper_valve_tick_driver_core_defines.svh -----
// Assertion macros used by the valve stepper driver checker.
// Depends on nothing; include it by its bare file name.
`ifndef STEPPER_VALVE_TICK_DRIVER_CORE_DEFINES_SVH
`define STEPPER_VALVE_TICK_DRIVER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SVTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ----- rtl/core/svtd_pkg.sv -----
// Package for the valve stepper driver: transaction types, per-channel state
// type, operation codes, coil sequence and reset constants. No dependencies.
`default_nettype none

package svtd_pkg;

	localparam int CHANNELS_DEF = 2;
	localparam int LIMIT_W = 10;
	localparam int STEPS_W = 12;
	localparam logic [LIMIT_W-1:0] TRAVEL_LIMIT_RESET = 10'd240;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_LOAD = 2'd1,
		OP_CAL  = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]                 operation;
		logic                       channel;
		logic signed [STEPS_W-1:0]  move_steps;
	} in_item_t;

	typedef struct packed {
		logic                       channel_out;
		logic [3:0]                 coils;
		logic [LIMIT_W-1:0]         position;
		logic signed [STEPS_W-1:0]  pending;
		logic                       busy_res;
	} out_item_t;

	typedef struct packed {
		logic signed [STEPS_W-1:0]  pending;
		logic [LIMIT_W-1:0]         position;
		logic                       armed;
		logic [1:0]                 phase;
	} chan_state_t;

	function automatic logic [3:0] fwd_coils(input logic [1:0] phase);
		logic [3:0] pattern;
		case (phase)
			2'd0: pattern = 4'b0011;
			2'd1: pattern = 4'b0110;
			2'd2: pattern = 4'b1100;
			default: pattern = 4'b1001;
		endcase
		return pattern;
	endfunction

	// The reverse sequence is the forward one read from the far end.
	function automatic logic [3:0] rev_coils(input logic [1:0] phase);
		return fwd_coils(~phase);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/svtd_step.sv -----
// Next-state logic for one valve channel: tick, load and calibrate.
// Depends on svtd_pkg.
`default_nettype none

module svtd_step (
	input  logic [1:0]                           operation,
	input  logic signed [svtd_pkg::STEPS_W-1:0]  move_steps,
	input  logic [svtd_pkg::LIMIT_W-1:0]         limit,
	input  svtd_pkg::chan_state_t                cur,
	output svtd_pkg::chan_state_t                nxt,
	output logic [3:0]                           coils
);
	import svtd_pkg::*;

	logic [LIMIT_W:0] pos_up;
	logic [LIMIT_W:0] pos_dn;
	logic [LIMIT_W:0] limit_ext;

	assign limit_ext = {1'b0, limit};
	assign pos_up = {1'b0, cur.position} + (LIMIT_W+1)'(1);
	assign pos_dn = (cur.position == '0) ? '0 : {1'b0, cur.position} - (LIMIT_W+1)'(1);

	always_comb begin
		nxt = cur;
		coils = 4'd0;
		unique case (op_t'(operation))
			OP_TICK: begin
				if (cur.pending > 0) begin
					coils = fwd_coils(cur.phase);
					nxt.phase = cur.phase + 2'd1;
					nxt.pending = cur.pending - STEPS_W'(1);
					nxt.position = (pos_up > limit_ext) ? limit : pos_up[LIMIT_W-1:0];
				end else if (cur.pending < 0) begin
					coils = rev_coils(cur.phase);
					nxt.phase = cur.phase + 2'd1;
					nxt.pending = cur.pending + STEPS_W'(1);
					nxt.position = (pos_dn > limit_ext) ? limit : pos_dn[LIMIT_W-1:0];
				end else if (cur.armed) begin
					nxt.pending = $signed({{(STEPS_W-LIMIT_W){1'b0}}, limit});
					nxt.armed = 1'b0;
				end
			end
			OP_LOAD: begin
				nxt.pending = move_steps;
			end
			OP_CAL: begin
				nxt.position = limit;
				nxt.pending = STEPS_W'(-$signed({{(STEPS_W-LIMIT_W){1'b0}}, limit}));
				nxt.armed = 1'b1;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/svtd_chan_regs.sv -----
// Per-channel state registers with read select and write-back.
// Depends on svtd_pkg.
`default_nettype none

module svtd_chan_regs #(
	parameter int CHANNELS = svtd_pkg::CHANNELS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   channel,
	input  logic                   wr_en,
	input  svtd_pkg::chan_state_t  wr_state,
	output svtd_pkg::chan_state_t  rd_state,
	output logic                   rd_hit
);
	import svtd_pkg::*;

	chan_state_t state_q [CHANNELS];

	assign rd_hit = int'(channel) < CHANNELS;

	always_comb begin
		rd_state = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (int'(channel) == i) begin
				rd_state = state_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				state_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (wr_en && int'(channel) == i) begin
					state_q[i] <= wr_state;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/stepper_valve_tick_driver_core.sv -----
// Valve stepper driver, top level: input register, channel state, result register.
// Depends on svtd_pkg, svtd_chan_regs and svtd_step.
//
// Usage:
// Each input transaction on item_valid/item_ready carries an operation (tick,
// load pending move, start calibration), a channel and a signed step count.
// Every transaction yields exactly one result transaction on
// result_valid/result_ready with the channel, the coil pattern of any step
// issued, the tracked position, the remaining pending steps and a busy flag.
// An accepted transaction is held in the input register and its result is written
// to the result register once that is empty or being taken. One transaction can
// be accepted every cycle while results are taken, even ticks on one channel back
// to back, as channel state updates in the same cycle. The user must write the
// travel limit via limit_we/limit_wdata only while the block is idle; this is not
// enforced by the block. Reset clears all channel state and sets the travel limit
// to 240. When the receiver stalls, the result holds and the input register fills;
// item_ready drops only when both stages are occupied and the result is not taken.
`default_nettype none

module stepper_valve_tick_driver_core #(
	parameter int CHANNELS = svtd_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  svtd_pkg::in_item_t            item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output svtd_pkg::out_item_t           result,
	input  logic                          limit_we,
	input  logic [svtd_pkg::LIMIT_W-1:0]  limit_wdata
);
	import svtd_pkg::*;

	in_item_t           item_s1;
	logic               valid_s1;
	out_item_t          result_q;
	logic               result_valid_q;
	logic [LIMIT_W-1:0] limit_q;

	logic               advance;
	logic               hit;
	chan_state_t        cur_state;
	chan_state_t        nxt_state;
	logic [3:0]         step_coils;
	out_item_t          result_d;

	assign advance = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result = result_q;

	svtd_chan_regs #(
		.CHANNELS(CHANNELS)
	) u_chan_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.channel  (item_s1.channel),
		.wr_en    (advance && hit),
		.wr_state (nxt_state),
		.rd_state (cur_state),
		.rd_hit   (hit)
	);

	svtd_step u_step (
		.operation  (item_s1.operation),
		.move_steps (item_s1.move_steps),
		.limit      (limit_q),
		.cur        (cur_state),
		.nxt        (nxt_state),
		.coils      (step_coils)
	);

	always_comb begin
		result_d = '0;
		result_d.channel_out = item_s1.channel;
		if (hit) begin
			result_d.coils = step_coils;
			result_d.position = nxt_state.position;
			result_d.pending = nxt_state.pending;
			result_d.busy_res = (nxt_state.pending != '0) || nxt_state.armed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid_q <= 1'b0;
			limit_q <= TRAVEL_LIMIT_RESET;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (limit_we) begin
				limit_q <= limit_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/svtd_checker.sv -----
// Port-level checker for the valve stepper driver and its bind to the top level.
// Depends on svtd_pkg and stepper_valve_tick_driver_core_defines.svh.
`default_nettype none
`include "stepper_valve_tick_driver_core_defines.svh"

module svtd_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  svtd_pkg::in_item_t   item,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  svtd_pkg::out_item_t  result
);
	import svtd_pkg::*;

	// A stalled result transaction keeps its payload.
	`SVTD_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

	// Any issued step drives two adjacent coils.
	`SVTD_ASSERT_NOW(a_coil_pattern, clk, arst_n, result_valid && result.coils != 4'd0, result.coils == 4'b0011 || result.coils == 4'b0110 || result.coils == 4'b1100 || result.coils == 4'b1001)

	// Remaining steps always report the channel as busy.
	`SVTD_ASSERT_NOW(a_busy_pending, clk, arst_n, result_valid && result.pending != '0, result.busy_res)

	// A step always leaves the channel busy or the pending count at zero.
	`SVTD_ASSERT_NOW(a_step_pending, clk, arst_n, result_valid && result.coils != 4'd0 && !result.busy_res, result.pending == '0)

endmodule

bind stepper_valve_tick_driver_core svtd_checker u_svtd_checker (.*);

`default_nettype wire

// ----- test/svtd_checker.sv -----
// Checker for the valve stepper driver: watches both transaction channels and the limit port,
// predicts each result from its own copy of the channel state, and compares field by field.
// Depends on svtd_pkg.
module svtd_scoreboard (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic                          item_ready,
	input  svtd_pkg::in_item_t            item,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  svtd_pkg::out_item_t           result,
	input  logic                          limit_we,
	input  logic [svtd_pkg::LIMIT_W-1:0]  limit_wdata,
	output int                            fail_count,
	output int                            awaited
);
	import svtd_pkg::*;

	localparam int NCH = CHANNELS_DEF;
	localparam logic [3:0] OPEN_SEQ [4] = '{4'b0011, 4'b0110, 4'b1100, 4'b1001};
	localparam logic [3:0] CLOSE_SEQ [4] = '{4'b1001, 4'b1100, 4'b0110, 4'b0011};

	logic signed [STEPS_W-1:0] steps_left [NCH];
	logic [LIMIT_W-1:0] valve_pos [NCH];
	logic cal_armed [NCH];
	logic [1:0] step_phase [NCH];
	logic [LIMIT_W-1:0] limit_now;
	out_item_t valve_results [$];
	out_item_t want;

	function automatic logic [LIMIT_W-1:0] clamp_to_limit(input int p);
		int q;
		q = p;
		if (q < 0)
			q = 0;
		if (q > int'(limit_now))
			q = int'(limit_now);
		return q[LIMIT_W-1:0];
	endfunction

	function automatic out_item_t advance_valve(input in_item_t it);
		out_item_t r;
		int ch;
		ch = it.channel;
		r = '0;
		r.channel_out = it.channel;
		case (it.operation)
			OP_TICK: begin
				if (steps_left[ch] > 0) begin
					r.coils = OPEN_SEQ[step_phase[ch]];
					step_phase[ch] = step_phase[ch] + 2'd1;
					steps_left[ch] = steps_left[ch] - 12'sd1;
					valve_pos[ch] = clamp_to_limit(int'(valve_pos[ch]) + 1);
				end else if (steps_left[ch] < 0) begin
					r.coils = CLOSE_SEQ[step_phase[ch]];
					step_phase[ch] = step_phase[ch] + 2'd1;
					steps_left[ch] = steps_left[ch] + 12'sd1;
					valve_pos[ch] = clamp_to_limit(int'(valve_pos[ch]) - 1);
				end else if (cal_armed[ch]) begin
					steps_left[ch] = $signed({2'b00, limit_now});
					cal_armed[ch] = 1'b0;
				end
			end
			OP_LOAD: begin
				steps_left[ch] = it.move_steps;
			end
			OP_CAL: begin
				valve_pos[ch] = limit_now;
				steps_left[ch] = 12'sd0 - $signed({2'b00, limit_now});
				cal_armed[ch] = 1'b1;
			end
			default: begin
			end
		endcase
		r.position = valve_pos[ch];
		r.pending = steps_left[ch];
		r.busy_res = (steps_left[ch] != 0) || cal_armed[ch];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v,
				got_v);
			fail_count++;
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				steps_left[c] = '0;
				valve_pos[c] = '0;
				cal_armed[c] = 1'b0;
				step_phase[c] = '0;
			end
			limit_now = TRAVEL_LIMIT_RESET;
			valve_results.delete();
			awaited = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (valve_results.size() == 0) begin
					$display("%0t: result transaction with none expected, expected none, actual 0x%0h",
						$time, result);
					fail_count++;
				end else begin
					want = valve_results.pop_front();
					check_field("channel_out", 16'(want.channel_out), 16'(result.channel_out));
					check_field("coils", 16'(want.coils), 16'(result.coils));
					check_field("position", 16'(want.position), 16'(result.position));
					check_field("pending", 16'(want.pending), 16'(result.pending));
					check_field("busy_res", 16'(want.busy_res), 16'(result.busy_res));
				end
			end
			if (item_valid && item_ready)
				valve_results.push_back(advance_valve(item));
			if (limit_we)
				limit_now = limit_wdata;
			awaited = valve_results.size();
		end
	end
endmodule

// ----- test/testbench.sv -----
// Top of the valve stepper driver test: clock, reset, stimulus, flow control and verdict.
// Depends on svtd_pkg, svtd_scoreboard and stepper_valve_tick_driver_core.
module testbench;
	import svtd_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 190;
	localparam int STALL_LIMIT = 1000;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_item_t item;
	logic result_valid;
	logic result_ready;
	out_item_t result;
	logic limit_we;
	logic [LIMIT_W-1:0] limit_wdata;
	int fail_count;
	int awaited;
	int items_sent;
	int idle_cycles;
	bit send_calm;
	bit recv_calm;
	logic [LIMIT_W-1:0] limit_set;
	logic [LIMIT_W-1:0] phase_limits [7];

	stepper_valve_tick_driver_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.limit_we(limit_we),
		.limit_wdata(limit_wdata)
	);

	svtd_scoreboard u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.limit_we(limit_we),
		.limit_wdata(limit_wdata),
		.fail_count(fail_count),
		.awaited(awaited)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic in_item_t make_item(input logic [1:0] op, input logic ch, input int steps);
		in_item_t it;
		it.operation = op;
		it.channel = ch;
		it.move_steps = steps[STEPS_W-1:0];
		return it;
	endfunction

	function automatic in_item_t random_item();
		int r;
		in_item_t it;
		r = $urandom_range(0, 99);
		it = make_item(OP_TICK, 1'($urandom_range(0, 1)), $urandom);
		if (r >= 60 && r < 80) begin
			it.operation = OP_LOAD;
			if ($urandom_range(0, 3) != 0)
				it.move_steps = 12'(int'($urandom_range(0, 40)) - 20);
		end else if (r >= 80 && r < 92) begin
			it.operation = OP_CAL;
		end else if (r >= 92) begin
			it.operation = OP_UNUSED;
		end
		return it;
	endfunction

	// Valid stays high into the next transaction when the drawn gap is zero.
	task automatic send_item(input in_item_t it);
		int gap;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		items_sent++;
		gap = send_calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (awaited != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		drain_results();
		limit_we <= 1'b1;
		limit_wdata <= v;
		limit_set = v;
		@(negedge clk);
		limit_we <= 1'b0;
	endtask

	task automatic tick_run(input logic ch, input int n);
		repeat (n)
			send_item(make_item(OP_TICK, ($urandom_range(0, 4) == 0) ? ~ch : ch, $urandom));
	endtask

	task automatic run_episode();
		int kind;
		int dist_abs;
		int ticks;
		logic ch;
		logic signed [STEPS_W-1:0] mv;
		kind = $urandom_range(0, 99);
		ch = 1'($urandom_range(0, 1));
		send_calm = ($urandom_range(0, 3) == 0);
		recv_calm = ($urandom_range(0, 3) == 0);
		if (kind < 55) begin
			if ($urandom_range(0, 9) == 0)
				mv = STEPS_W'($urandom);
			else
				mv = 12'(int'($urandom_range(0, 24)) - 12);
			dist_abs = (mv < 0) ? -int'(mv) : int'(mv);
			ticks = ((dist_abs > 14) ? 14 : dist_abs) + $urandom_range(0, 2);
			send_item(make_item(OP_LOAD, ch, int'(mv)));
			tick_run(ch, ticks);
		end else if (kind < 72) begin
			if (limit_set <= 40)
				ticks = 2 * int'(limit_set) + $urandom_range(0, 3);
			else
				ticks = $urandom_range(1, 8);
			send_item(make_item(OP_CAL, ch, $urandom));
			tick_run(ch, ticks);
		end else begin
			repeat ($urandom_range(1, 4))
				send_item(random_item());
		end
	endtask

	initial begin
		int r;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			r = recv_calm ? 0 : $urandom_range(0, 6);
			if (r > 0) begin
				result_ready <= 1'b0;
				repeat (r) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int start;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		limit_we = 1'b0;
		limit_wdata = '0;
		items_sent = 0;
		idle_cycles = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		limit_set = TRAVEL_LIMIT_RESET;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Idle tick, unused code, extreme loads, both step directions.
		send_item(make_item(OP_TICK, 1'b0, 0));
		send_item(make_item(OP_UNUSED, 1'b1, -1));
		send_item(make_item(OP_LOAD, 1'b1, -2048));
		send_item(make_item(OP_TICK, 1'b1, 0));
		send_item(make_item(OP_LOAD, 1'b1, 0));
		send_item(make_item(OP_LOAD, 1'b0, 2047));
		send_item(make_item(OP_TICK, 1'b0, 0));
		send_item(make_item(OP_LOAD, 1'b0, 5));
		repeat (6)
			send_item(make_item(OP_TICK, 1'b0, 0));
		send_item(make_item(OP_LOAD, 1'b0, -2));
		repeat (2)
			send_item(make_item(OP_TICK, 1'b0, 0));
		// Calibration, then the reload once the reverse run is cut short.
		send_item(make_item(OP_CAL, 1'b1, 0));
		send_item(make_item(OP_TICK, 1'b1, 0));
		send_item(make_item(OP_LOAD, 1'b1, 0));
		send_item(make_item(OP_TICK, 1'b1, 0));
		// Position left above a lowered limit, then a limit of zero.
		write_limit(10'd1023);
		send_item(make_item(OP_CAL, 1'b0, 0));
		write_limit(10'd10);
		send_item(make_item(OP_LOAD, 1'b0, 1));
		repeat (2)
			send_item(make_item(OP_TICK, 1'b0, 0));
		write_limit(10'd0);
		send_item(make_item(OP_LOAD, 1'b0, 5));
		send_item(make_item(OP_TICK, 1'b0, 0));
		send_item(make_item(OP_CAL, 1'b1, 0));
		send_item(make_item(OP_TICK, 1'b1, 0));

		phase_limits[0] = 10'd1;
		phase_limits[1] = 10'd3;
		phase_limits[2] = 10'($urandom_range(2, 30));
		phase_limits[3] = 10'd0;
		phase_limits[4] = 10'd1023;
		phase_limits[5] = 10'($urandom_range(4, 60));
		phase_limits[6] = 10'd240;
		for (int p = 0; p < 7; p++) begin
			write_limit(phase_limits[p]);
			start = items_sent;
			while (items_sent - start < ITEMS_PER_PHASE)
				run_episode();
		end

		drain_results();
		repeat (4) @(negedge clk);
		if (fail_count == 0 && awaited == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
